### sv/joint_chain_tilt_angles_assert.svh
// Assertion macros for the joint chain tilt block
`ifndef JOINT_CHAIN_TILT_ANGLES_ASSERT_SVH
`define JOINT_CHAIN_TILT_ANGLES_ASSERT_SVH
// implication that must hold at every clock edge outside reset
`define JCT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// implication checked on the cycle after the trigger
`define JCT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### sv/jcta_pkg.sv
// Package: payload types, constants and the CORDIC angle table
package jcta_pkg;
  typedef struct packed {
    logic signed [15:0] joint_angle;
    logic signed [15:0] twist_angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               last_joint;
  } in_item_t;

  typedef struct packed {
    logic [14:0] tilt_angle;
    logic        last_out;
  } out_item_t;

  localparam int QDEPTH = 2;
  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;
  localparam logic signed [17:0] ENTRY_MAX = 18'sd131071;
  localparam logic signed [17:0] ENTRY_MIN = -18'sd131072;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SC_TH, ST_SC_AL, ST_PROD, ST_MAT, ST_GZ, ST_SQRT, ST_ACOS, ST_OUT
  } be_state_t;

  // front-end classification carried through the queue
  typedef struct packed {
    in_item_t item;
    logic     chain_end;
  } job_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    unique case (i)
      4'd0: atan_q16 = 20'sd51472;  4'd1: atan_q16 = 20'sd30386;
      4'd2: atan_q16 = 20'sd16055;  4'd3: atan_q16 = 20'sd8150;
      4'd4: atan_q16 = 20'sd4091;   4'd5: atan_q16 = 20'sd2047;
      4'd6: atan_q16 = 20'sd1024;   4'd7: atan_q16 = 20'sd512;
      4'd8: atan_q16 = 20'sd256;    4'd9: atan_q16 = 20'sd128;
      4'd10: atan_q16 = 20'sd64;    4'd11: atan_q16 = 20'sd32;
      4'd12: atan_q16 = 20'sd16;    4'd13: atan_q16 = 20'sd8;
      4'd14: atan_q16 = 20'sd4;     default: atan_q16 = 20'sd2;
    endcase
  endfunction
endpackage

### sv/jcta_front.sv
// Front end: accepts joints, counts the chain and marks its end
module jcta_front #(
  parameter int MAX_JOINTS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jcta_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output jcta_pkg::job_t    q_data
);
  logic [3:0] joint_count_r, joint_count_nxt;
  jcta_pkg::job_t buf_r [jcta_pkg::QDEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop, end_now;
  logic [3:0] cnt_inc;

  assign in_ready = (cnt_r != 2'(jcta_pkg::QDEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = buf_r[rp_r];
  assign cnt_inc = joint_count_r + 4'd1;
  assign end_now = in_data.last_joint || (cnt_inc >= 4'(MAX_JOINTS));
  assign joint_count_nxt = push ? (end_now ? 4'd0 : cnt_inc) : joint_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= 4'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      joint_count_r <= joint_count_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= '{item: in_data, chain_end: end_now};
  end

`include "joint_chain_tilt_angles_assert.svh"
  `JCT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 2'(jcta_pkg::QDEPTH))
  `JCT_ASSERT_IMP(a_jc_bound, 1'b1, joint_count_r < 4'(MAX_JOINTS))
  `JCT_ASSERT_NXT(a_end_clear, push && end_now, joint_count_r == 4'd0)
endmodule

### sv/jcta_back.sv
// Back end: CORDIC sin/cos, matrix update, gz, isqrt and CORDIC arccos
module jcta_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  jcta_pkg::job_t     q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jcta_pkg::out_item_t out_data
);
  jcta_pkg::be_state_t st_r, st_nxt;
  jcta_pkg::job_t job_r;
  logic [3:0] it_r;
  logic [3:0] k_r;
  logic signed [19:0] cx_r, cy_r, cz_r;
  logic neg_r;
  logic signed [17:0] ct_r, st2_r, ca_r, sa_r;
  logic signed [17:0] stca_r, stsa_r, ctca_r, ctsa_r;
  logic signed [17:0] m_r [9];
  logic signed [17:0] n_r [9];
  logic signed [47:0] acc_r;
  logic signed [17:0] gz_r;
  logic [31:0] sv_r, sr_r, sb_r;
  logic [14:0] tilt_r;
  logic last_r;
  logic outv_r;

  // combinational helpers
  logic signed [15:0] ang;
  logic signed [15:0] ared;
  logic aneg;
  logic signed [19:0] xs, ys, dz;
  logic signed [19:0] rc, rs;
  logic signed [17:0] cc, cs;
  logic signed [35:0] p0, p1, p2, p3;
  logic signed [33:0] g0, g1, g2;
  logic signed [17:0] f0, f1, f2;
  logic signed [17:0] e0, e1, e2;
  logic signed [17:0] gzc;
  logic signed [47:0] sum3;
  logic signed [47:0] rnd;
  logic [1:0] kc, kr;
  logic [31:0] sq_t;
  logic signed [19:0] zr;

  function automatic logic signed [17:0] rnd14p(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd8192) >>> 14;
    return t[17:0];
  endfunction

  function automatic logic signed [17:0] clip(input logic signed [47:0] v,
                                              input logic signed [17:0] lo,
                                              input logic signed [17:0] hi);
    if (v < 48'(lo)) return lo;
    else if (v > 48'(hi)) return hi;
    else return v[17:0];
  endfunction

  assign ang = (st_r == jcta_pkg::ST_SC_TH) ? job_r.item.joint_angle : job_r.item.twist_angle;
  always_comb begin
    aneg = 1'b0;
    ared = ang;
    if (ang > jcta_pkg::HALF_PI_Q13) begin
      ared = ang - jcta_pkg::PI_Q13; aneg = 1'b1;
    end else if (ang < -jcta_pkg::HALF_PI_Q13) begin
      ared = ang + jcta_pkg::PI_Q13; aneg = 1'b1;
    end
  end
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign dz = jcta_pkg::atan_q16(it_r);
  assign rc = (cx_r + 20'sd2) >>> 2;
  assign rs = (cy_r + 20'sd2) >>> 2;
  assign cc = clip(48'(rc), -jcta_pkg::ONE_Q14, jcta_pkg::ONE_Q14);
  assign cs = clip(48'(rs), -jcta_pkg::ONE_Q14, jcta_pkg::ONE_Q14);

  // matrix column kc (new x/y/z frame axis), row kr
  assign kc = (k_r < 4'd3) ? 2'd0 : (k_r < 4'd6) ? 2'd1 : 2'd2;
  assign kr = 2'(k_r - 4'(kc) * 4'd3);
  assign e0 = m_r[kr];
  assign e1 = m_r[4'd3 + 4'(kr)];
  assign e2 = m_r[4'd6 + 4'(kr)];
  always_comb begin
    unique case (kc)
      2'd0: begin f0 = ct_r; f1 = stca_r; f2 = stsa_r; end
      2'd1: begin f0 = -st2_r; f1 = ctca_r; f2 = ctsa_r; end
      default: begin f0 = 18'sd0; f1 = -sa_r; f2 = ca_r; end
    endcase
  end
  assign p0 = f0 * e0;
  assign p1 = f1 * e1;
  assign p2 = f2 * e2;
  assign sum3 = 48'(p0) + 48'(p1) + 48'(p2);
  assign g0 = m_r[2] * job_r.item.axis_x;
  assign g1 = m_r[5] * job_r.item.axis_y;
  assign g2 = m_r[8] * job_r.item.axis_z;
  assign rnd = (acc_r + 48'sd8192) >>> 14;
  assign gzc = clip(rnd, -jcta_pkg::ONE_Q14, jcta_pkg::ONE_Q14);
  assign p3 = gzc * gzc;
  assign sq_t = sr_r + sb_r;
  assign zr = (cz_r + 20'sd4) >>> 3;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      jcta_pkg::ST_IDLE: if (q_valid) st_nxt = jcta_pkg::ST_SC_TH;
      jcta_pkg::ST_SC_TH: if (it_r == 4'd15 && k_r == 4'd1) st_nxt = jcta_pkg::ST_SC_AL;
      jcta_pkg::ST_SC_AL: if (it_r == 4'd15 && k_r == 4'd1) st_nxt = jcta_pkg::ST_PROD;
      jcta_pkg::ST_PROD: if (k_r == 4'd4) st_nxt = jcta_pkg::ST_MAT;
      jcta_pkg::ST_MAT: if (k_r == 4'd9) st_nxt = jcta_pkg::ST_GZ;
      jcta_pkg::ST_GZ: if (k_r == 4'd1) st_nxt = jcta_pkg::ST_SQRT;
      jcta_pkg::ST_SQRT: if (sb_r == 32'd0) st_nxt = jcta_pkg::ST_ACOS;
      jcta_pkg::ST_ACOS: if (it_r == 4'd15) st_nxt = jcta_pkg::ST_OUT;
      jcta_pkg::ST_OUT: if (!outv_r) st_nxt = jcta_pkg::ST_IDLE;
      default: st_nxt = jcta_pkg::ST_IDLE;
    endcase
  end

  assign q_ready = (st_r == jcta_pkg::ST_IDLE);
  assign out_valid = outv_r;
  assign out_data = '{tilt_angle: tilt_r, last_out: last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= jcta_pkg::ST_IDLE;
      outv_r <= 1'b0;
      for (int i = 0; i < 9; i++) m_r[i] <= (i % 4 == 0) ? jcta_pkg::ONE_Q14 : 18'sd0;
      it_r <= 4'd0;
      k_r <= 4'd0;
    end else begin
      st_r <= st_nxt;
      if (outv_r && out_ready) outv_r <= 1'b0;
      unique case (st_r)
        jcta_pkg::ST_IDLE: begin
          it_r <= 4'd0; k_r <= 4'd0;
          if (q_valid) job_r <= q_data;
        end
        jcta_pkg::ST_SC_TH, jcta_pkg::ST_SC_AL: begin
          if (k_r == 4'd0) begin
            // load reduced angle, phase 1 = iterate
            cx_r <= jcta_pkg::CORDIC_GAIN; cy_r <= 20'sd0;
            cz_r <= 20'(ared) <<< 3; neg_r <= aneg; k_r <= 4'd1; it_r <= 4'd0;
          end else if (it_r == 4'd15 && k_r == 4'd2) begin
            k_r <= 4'd1;
          end else begin
            if (cz_r >= 0) begin
              cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - dz;
            end else begin
              cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + dz;
            end
            it_r <= it_r + 4'd1;
            if (it_r == 4'd15) k_r <= 4'd0;
          end
        end
        default: ;
      endcase
      unique case (st_r)
        jcta_pkg::ST_PROD: begin
          unique case (k_r)
            4'd0: begin
              ca_r <= neg_r ? -cc : cc; sa_r <= neg_r ? -cs : cs;
            end
            4'd1: stca_r <= rnd14p(st2_r * (neg_r ? -cc : cc));
            4'd2: stsa_r <= rnd14p(st2_r * (neg_r ? -cs : cs));
            4'd3: ctca_r <= rnd14p(ct_r * (neg_r ? -cc : cc));
            default: ctsa_r <= rnd14p(ct_r * (neg_r ? -cs : cs));
          endcase
          k_r <= (k_r == 4'd4) ? 4'd0 : k_r + 4'd1;
        end
        jcta_pkg::ST_MAT: begin
          if (k_r == 4'd9) begin
            for (int i = 0; i < 9; i++) m_r[i] <= n_r[i];
            k_r <= 4'd0;
          end else begin
            n_r[k_r] <= clip(((sum3 + 48'sd8192) >>> 14), jcta_pkg::ENTRY_MIN,
                             jcta_pkg::ENTRY_MAX);
            k_r <= k_r + 4'd1;
          end
        end
        jcta_pkg::ST_GZ: begin
          if (k_r == 4'd0) begin
            acc_r <= 48'(g0) + 48'(g1) + 48'(g2);
            k_r <= 4'd1;
          end else begin
            gz_r <= gzc;
            sv_r <= 32'h1000_0000 - 32'(p3);
            sr_r <= 32'd0; sb_r <= 32'h1000_0000; k_r <= 4'd0;
          end
        end
        jcta_pkg::ST_SQRT: begin
          if (sb_r != 32'd0) begin
            if (sv_r >= sq_t) begin
              sv_r <= sv_r - sq_t; sr_r <= (sr_r >> 1) + sb_r;
            end else begin
              sr_r <= sr_r >> 1;
            end
            sb_r <= sb_r >> 2;
          end else begin
            it_r <= 4'd0;
            if (gz_r < 0) begin
              cx_r <= 20'(sr_r) <<< 2; cy_r <= -(20'(gz_r) <<< 2);
              cz_r <= jcta_pkg::HALF_PI_Q16;
            end else begin
              cx_r <= 20'(gz_r) <<< 2; cy_r <= 20'(sr_r) <<< 2; cz_r <= 20'sd0;
            end
          end
        end
        jcta_pkg::ST_ACOS: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + dz;
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - dz;
          end
          it_r <= it_r + 4'd1;
        end
        jcta_pkg::ST_OUT: begin
          if (!outv_r) begin
            tilt_r <= 15'(clip(48'(zr), 18'sd0, 18'sd25736));
            last_r <= job_r.chain_end;
            outv_r <= 1'b1;
            if (job_r.chain_end)
              for (int i = 0; i < 9; i++)
                m_r[i] <= (i % 4 == 0) ? jcta_pkg::ONE_Q14 : 18'sd0;
          end
        end
        default: ;
      endcase
      // theta results are kept when the twist pass starts
      if (st_r == jcta_pkg::ST_SC_AL && k_r == 4'd0) begin
        ct_r <= neg_r ? -cc : cc; st2_r <= neg_r ? -cs : cs;
      end
    end
  end

`include "joint_chain_tilt_angles_assert.svh"
  `JCT_ASSERT_NXT(a_out_hold, outv_r && !out_ready, outv_r && $stable(out_data))
  `JCT_ASSERT_NXT(a_take, q_valid && q_ready, st_r == jcta_pkg::ST_SC_TH)
  `JCT_ASSERT_IMP(a_tilt_rng, outv_r, tilt_r <= 15'd25736)
endmodule

### sv/joint_chain_tilt_angles.sv
// Top level of the joint chain tilt block
//  channel | dir | payload
//  in_     | in  | jcta_pkg::in_item_t  (one joint per transfer)
//  out_    | out | jcta_pkg::out_item_t (one tilt per joint)
// In the back end each joint takes two 16-step CORDIC rotations, 9 serial
// matrix entries, a 15-step isqrt and a 16-step CORDIC vectoring pass.
// The two-entry queue lets the front take joints while the back is busy.
// Synchronous reset sets the matrix to identity and the joint count to zero.
// A stalled result holds in the output register; a next result waits in ST_OUT.
module joint_chain_tilt_angles #(
  parameter int MAX_JOINTS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jcta_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jcta_pkg::out_item_t out_data
);
  logic q_valid, q_ready;
  jcta_pkg::job_t q_data;

  jcta_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .q_valid, .q_ready, .q_data
  );
  jcta_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .out_valid, .out_ready, .out_data
  );
endmodule
